FILE: hw/rtl/mjpeg_fd_pkg.sv
package mjpeg_fd_pkg;

   localparam logic [7:0] MARK_FF  = 8'hFF;
   localparam logic [7:0] MARK_SOI = 8'hD8;
   localparam logic [7:0] MARK_EOI = 8'hD9;

   localparam int FRAME_BYTES_WIDTH = 17;
   localparam logic [FRAME_BYTES_WIDTH-1:0] MAX_FRAME_RESET = 17'd98304;

   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_PTR_WIDTH   = 2;
   localparam int RSP_FILL_WIDTH  = 3;

   typedef struct packed {
      logic [7:0]                   out_byte;
      logic                         first_of_frame;
      logic                         last_of_frame;
      logic                         frame_dropped;
      logic [FRAME_BYTES_WIDTH-1:0] frame_bytes;
   } result_type;

endpackage

FILE: hw/rtl/mjpeg_frame_deframer.sv
// Splits a motion JPEG byte stream into frames at one byte per clock. Outside
// a frame the block hunts for FF D8 and then sends FF (tuser first_of_frame)
// and D8 as two items; inside a frame every byte is passed on with its running
// count, and the D9 of FF D9 is sent with tlast and the frame length. A byte
// that would push the frame past csr_data's limit (or fill the counter) gives
// one dropped item instead and hunting resumes with that byte. Every accepted
// item is registered in the queue before it is shown. Results go through a
// four-entry output queue; req_tready is high while the queue holds two items
// or fewer, so a byte that makes two items always finds room, and a stalled
// result side holds the input back once three items are waiting. Bytes that
// make no item while hunting are still taken. csr_ready is always high; write
// the limit only while idle.
module mjpeg_frame_deframer #(
   parameter int COUNT_WIDTH = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [24:8] frame_bytes, rest zero
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,   // [0] first_of_frame, [1] frame_dropped
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);

   localparam int FBW  = mjpeg_fd_pkg::FRAME_BYTES_WIDTH;
   localparam int WIDE = (COUNT_WIDTH > FBW) ? COUNT_WIDTH : FBW;
   localparam logic [COUNT_WIDTH-1:0] COUNT_TWO = COUNT_WIDTH'(2);
   localparam logic [FBW-1:0] FB_ONE = FBW'(1);
   localparam logic [FBW-1:0] FB_TWO = FBW'(2);

   logic [FBW-1:0]         max_frame_bytes_ff;
   logic                   in_frame_ff, in_frame_in;
   logic                   prev_was_ff_ff, prev_was_ff_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;

   mjpeg_fd_pkg::result_type mem_ff [mjpeg_fd_pkg::RSP_QUEUE_DEPTH];
   logic [mjpeg_fd_pkg::RSP_PTR_WIDTH-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mjpeg_fd_pkg::RSP_PTR_WIDTH-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mjpeg_fd_pkg::RSP_FILL_WIDTH-1:0] fill_ff, fill_in;

   logic                     accept, pop;
   logic [1:0]               push_count;
   mjpeg_fd_pkg::result_type entry0, entry1;
   logic [WIDE-1:0]          count_wide, count_inc_wide, max_wide;
   logic [COUNT_WIDTH-1:0]   count_inc;
   logic                     over_limit, is_ff;
   mjpeg_fd_pkg::result_type head;

   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (fill_ff <= mjpeg_fd_pkg::RSP_FILL_WIDTH'(2));

   assign count_inc      = byte_count_ff + COUNT_WIDTH'(1);
   assign count_wide     = WIDE'(byte_count_ff);
   assign count_inc_wide = WIDE'(count_inc);
   assign max_wide       = WIDE'(max_frame_bytes_ff);
   assign over_limit     = (count_wide >= max_wide) || (&byte_count_ff);
   assign is_ff          = (req_tdata == mjpeg_fd_pkg::MARK_FF);

   always_comb begin
      in_frame_in    = in_frame_ff;
      prev_was_ff_in = prev_was_ff_ff;
      byte_count_in  = byte_count_ff;
      push_count     = 2'd0;
      entry0         = '0;
      entry1         = '0;
      if (!in_frame_ff) begin
         if (prev_was_ff_ff && req_tdata == mjpeg_fd_pkg::MARK_SOI) begin
            in_frame_in           = 1'b1;
            prev_was_ff_in        = 1'b0;
            byte_count_in         = COUNT_TWO;
            push_count            = 2'd2;
            entry0.out_byte       = mjpeg_fd_pkg::MARK_FF;
            entry0.first_of_frame = 1'b1;
            entry0.frame_bytes    = FB_ONE;
            entry1.out_byte       = mjpeg_fd_pkg::MARK_SOI;
            entry1.frame_bytes    = FB_TWO;
         end else begin
            prev_was_ff_in = is_ff;
         end
      end else if (over_limit) begin
         in_frame_in          = 1'b0;
         prev_was_ff_in       = is_ff;
         byte_count_in        = '0;
         push_count           = 2'd1;
         entry0.frame_dropped = 1'b1;
         entry0.frame_bytes   = count_wide[FBW-1:0];
      end else begin
         push_count         = 2'd1;
         entry0.out_byte    = req_tdata;
         entry0.frame_bytes = count_inc_wide[FBW-1:0];
         if (prev_was_ff_ff && req_tdata == mjpeg_fd_pkg::MARK_EOI) begin
            in_frame_in          = 1'b0;
            prev_was_ff_in       = 1'b0;
            byte_count_in        = '0;
            entry0.last_of_frame = 1'b1;
         end else begin
            prev_was_ff_in = is_ff;
            byte_count_in  = count_inc;
         end
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (accept) begin
         wr_ptr_in = wr_ptr_ff + mjpeg_fd_pkg::RSP_PTR_WIDTH'(push_count);
         fill_in   = fill_in + mjpeg_fd_pkg::RSP_FILL_WIDTH'(push_count);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + mjpeg_fd_pkg::RSP_PTR_WIDTH'(1);
         fill_in   = fill_in - mjpeg_fd_pkg::RSP_FILL_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_bytes_ff <= mjpeg_fd_pkg::MAX_FRAME_RESET;
         in_frame_ff        <= 1'b0;
         prev_was_ff_ff     <= 1'b0;
         byte_count_ff      <= '0;
         wr_ptr_ff          <= '0;
         rd_ptr_ff          <= '0;
         fill_ff            <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_frame_bytes_ff <= csr_data;
         end
         if (accept) begin
            in_frame_ff    <= in_frame_in;
            prev_was_ff_ff <= prev_was_ff_in;
            byte_count_ff  <= byte_count_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= entry0;
      end
      if (accept && push_count == 2'd2) begin
         mem_ff[wr_ptr_ff + mjpeg_fd_pkg::RSP_PTR_WIDTH'(1)] <= entry1;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = {7'd0, head.frame_bytes, head.out_byte};
   assign rsp_tlast  = head.last_of_frame;
   assign rsp_tuser  = {head.frame_dropped, head.first_of_frame};

endmodule

FILE: hw/rtl/mjpeg_fd_checker.sv
module mjpeg_fd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [1:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   a_first_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[7:0] == mjpeg_fd_pkg::MARK_FF
         && rsp_tdata[24:8] == 17'd1 && !rsp_tlast && !rsp_tuser[1])
      else $error("frame start item is malformed");

   a_first_then_soi: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[0] |=> rsp_tvalid
         && rsp_tdata[7:0] == mjpeg_fd_pkg::MARK_SOI && rsp_tdata[24:8] == 17'd2)
      else $error("start marker second byte not ready after first");

   a_drop_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[7:0] == 8'h00 && !rsp_tlast)
      else $error("dropped item carries data or end mark");

   a_last_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[7:0] == mjpeg_fd_pkg::MARK_EOI
         && rsp_tdata[24:8] >= 17'd3)
      else $error("frame end item is malformed");

endmodule

bind mjpeg_frame_deframer mjpeg_fd_checker u_mjpeg_fd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
